// File: hdl/uvs_pkg.sv
// Shared types and constants for the sphere vertex generator
`default_nettype none
package uvs_pkg;
   localparam int CORDIC_STEPS = 24;
   localparam logic signed [35:0] CORDIC_START = 36'sd652032874;
   localparam int POLE_LIMIT = 16368;
   localparam int ONE_Q14 = 16384;
   localparam int POS_LIMIT = 65535;
   localparam logic [1:0] CSR_SLICES = 2'd0;
   localparam logic [1:0] CSR_RINGS = 2'd1;
   localparam logic [1:0] CSR_RADIUS = 2'd2;

   // arctangent per step in 2^-32 turn units
   function automatic logic signed [35:0] atan_turn(input logic [4:0] idx);
      logic signed [35:0] v;
      begin
         unique case (idx)
            5'd0: v = 36'sd536870912;  5'd1: v = 36'sd316933406;
            5'd2: v = 36'sd167458907;  5'd3: v = 36'sd85004756;
            5'd4: v = 36'sd42667331;   5'd5: v = 36'sd21354465;
            5'd6: v = 36'sd10679838;   5'd7: v = 36'sd5340245;
            5'd8: v = 36'sd2670163;    5'd9: v = 36'sd1335087;
            5'd10: v = 36'sd667544;    5'd11: v = 36'sd333772;
            5'd12: v = 36'sd166886;    5'd13: v = 36'sd83443;
            5'd14: v = 36'sd41722;     5'd15: v = 36'sd20861;
            5'd16: v = 36'sd10430;     5'd17: v = 36'sd5215;
            5'd18: v = 36'sd2608;      5'd19: v = 36'sd1304;
            5'd20: v = 36'sd652;       5'd21: v = 36'sd326;
            5'd22: v = 36'sd163;       5'd23: v = 36'sd81;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

   // one rotation datapath lane
   typedef struct packed {
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [35:0] z;
      logic [1:0]         quad;
   } rot_type;

   // side payload carried alongside the rotation lanes
   typedef struct packed {
      logic        err;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
      logic [15:0] radius;
   } side_type;
endpackage
`default_nettype wire

// File: hdl/uvs_stream_if.sv
// Valid/ready stream interface with a generic payload
`default_nettype none
interface uvs_stream_if #(parameter int W = 18);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/uvs_cfg_if.sv
// Configuration write channel
`default_nettype none
interface uvs_cfg_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/uvs_divider.sv
// Pipelined restoring divider: one quotient bit per stage
`default_nettype none
module uvs_divider #(
   parameter int NW = 41,
   parameter int DW = 9,
   parameter int TW = 1
) (
   input  wire logic          clock,
   input  wire logic          enable,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   input  wire logic [TW-1:0] tag_in,
   output      logic [NW-1:0] quo,
   output      logic [TW-1:0] tag_out
);
   logic [NW-1:0] q_ff [NW+1];
   logic [DW:0]   rem_ff [NW+1];
   logic [DW-1:0] den_ff [NW+1];
   logic [TW-1:0] tag_ff [NW+1];

   always_ff @(posedge clock) begin
      if (enable) begin
         q_ff[0]   <= num;
         rem_ff[0] <= '0;
         den_ff[0] <= den;
         tag_ff[0] <= tag_in;
      end
   end

   // each cell shifts in one numerator bit and tries a subtract
   for (genvar i = 0; i < NW; i++) begin : g_cell
      logic [DW+1:0] trial_in;
      logic [DW+1:0] diff_in;
      always_comb begin
         trial_in = {rem_ff[i], q_ff[i][NW-1]};
         diff_in  = trial_in - {2'b00, den_ff[i]};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            if (!diff_in[DW+1]) begin
               rem_ff[i+1] <= diff_in[DW:0];
            end else begin
               rem_ff[i+1] <= trial_in[DW:0];
            end
            q_ff[i+1]   <= {q_ff[i][NW-2:0], ~diff_in[DW+1]};
            den_ff[i+1] <= den_ff[i];
            tag_ff[i+1] <= tag_ff[i];
         end
      end
   end

   assign quo     = q_ff[NW];
   assign tag_out = tag_ff[NW];
endmodule
`default_nettype wire

// File: hdl/uvs_cordic.sv
// Chain of CORDIC rotation cells, one micro-rotation per cell
`default_nettype none
module uvs_cordic (
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire logic [31:0] angle,
   output      logic signed [35:0] cos_out,
   output      logic signed [35:0] sin_out
);
   uvs_pkg::rot_type st_ff [uvs_pkg::CORDIC_STEPS+1];

   always_ff @(posedge clock) begin
      if (enable) begin
         st_ff[0].x    <= uvs_pkg::CORDIC_START;
         st_ff[0].y    <= '0;
         st_ff[0].z    <= {6'd0, angle[29:0]};
         st_ff[0].quad <= angle[31:30];
      end
   end

   for (genvar i = 0; i < uvs_pkg::CORDIC_STEPS; i++) begin : g_cell
      logic signed [35:0] dx_in, dy_in;
      uvs_pkg::rot_type nx_in;
      always_comb begin
         dx_in = st_ff[i].y >>> i;
         dy_in = st_ff[i].x >>> i;
         nx_in = st_ff[i];
         if (!st_ff[i].z[35]) begin
            nx_in.x = st_ff[i].x - dx_in;
            nx_in.y = st_ff[i].y + dy_in;
            nx_in.z = st_ff[i].z - uvs_pkg::atan_turn(5'(i));
         end else begin
            nx_in.x = st_ff[i].x + dx_in;
            nx_in.y = st_ff[i].y - dy_in;
            nx_in.z = st_ff[i].z + uvs_pkg::atan_turn(5'(i));
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            st_ff[i+1] <= nx_in;
         end
      end
   end

   // quadrant mapping
   always_comb begin
      uvs_pkg::rot_type f;
      f = st_ff[uvs_pkg::CORDIC_STEPS];
      unique case (f.quad)
         2'd0: begin cos_out = f.x;  sin_out = f.y;  end
         2'd1: begin cos_out = -f.y; sin_out = f.x;  end
         2'd2: begin cos_out = -f.x; sin_out = -f.y; end
         default: begin cos_out = f.y; sin_out = -f.x; end
      endcase
   end
endmodule
`default_nettype wire

// File: hdl/uv_sphere_vertex_generator_top.sv
// UV sphere vertex generator top level
//
// Usage: send a beat of (ring_index, slice_index) on req_; one result beat
// with position, normal, tangent, texture coordinates and index_error comes
// out on rsp_, in order. csr_ writes slice_count (0), ring_count (1) and
// radius (2); write only while no beat is in flight.
// Throughput: one beat per cycle while the receiver takes results. A beat
// runs from the accepting edge to rsp_valid through the angle dividers (input
// register and 41 quotient-bit cells), the CORDIC cell chain (input register
// and 24 cells), then stage A products, stage B rounding and the output
// register; the angle divider's cell chain is the longest part of that path.
// The whole pipeline advances only when the output register is free or
// being taken, so a stalled receiver holds everything in place and
// req_ready falls; no beat is lost.
// Reset (synchronous, active high) empties the pipeline and restores
// slice_count 16, ring_count 16, radius 1.0.
`default_nettype none
module uv_sphere_vertex_generator_top #(
   parameter int MAX_RINGS = 256,
   parameter int MAX_SLICES = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   uvs_stream_if.sink   req,
   uvs_stream_if.source rsp,
   uvs_cfg_if.sink      csr
);
   localparam int NW = 41;
   localparam int LAT = NW + 1 + uvs_pkg::CORDIC_STEPS + 1 + 3;

   logic [8:0]  slices_ff, rings_ff;
   logic [15:0] radius_ff;
   logic [LAT-2:0] vld_ff;
   logic        adv;
   logic        out_vld_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         slices_ff <= 9'd16;
         rings_ff  <= 9'd16;
         radius_ff <= 16'd256;
      end else if (csr.valid) begin
         unique case (csr.index)
            uvs_pkg::CSR_SLICES: slices_ff <= csr.data[8:0];
            uvs_pkg::CSR_RINGS:  rings_ff  <= csr.data[8:0];
            uvs_pkg::CSR_RADIUS: radius_ff <= csr.data;
            default: ;
         endcase
      end
   end

   assign adv = !out_vld_ff || rsp.ready;
   assign req.ready = adv;

   // clamped counts and index check
   logic [8:0] rr, ss, ri, si;
   logic err;
   always_comb begin
      rr = (rings_ff < 9'd2) ? 9'd2 :
           ({23'd0, rings_ff} > MAX_RINGS) ? 9'(MAX_RINGS) : rings_ff;
      ss = (slices_ff < 9'd3) ? 9'd3 :
           ({23'd0, slices_ff} > MAX_SLICES) ? 9'(MAX_SLICES) : slices_ff;
      ri = req.data[17:9];
      si = req.data[8:0];
      err = (ri > rr) || (si > ss);
   end

   // four dividers: two angles, two texture coordinates
   logic [NW-1:0] q_ph, q_th, q_u, q_v;
   logic [15:0] rad_d;
   logic err_d;
   logic [NW-1:0] n_ph, n_th, n_u, n_v;
   always_comb begin
      n_ph = ({32'd0, ri} << 31) + NW'(rr >> 1);
      n_th = ({32'd0, si} << 32) + NW'(ss >> 1);
      n_u  = ({32'd0, ss - si} << 16) + NW'(ss >> 1);
      n_v  = ({32'd0, ri} << 16) + NW'(rr >> 1);
   end
   uvs_divider #(.NW(NW), .DW(9), .TW(17)) u_div_ph (
      .clock(clock), .enable(adv), .num(n_ph), .den(rr),
      .tag_in({err, radius_ff}), .quo(q_ph), .tag_out({err_d, rad_d}));
   uvs_divider #(.NW(NW), .DW(9), .TW(1)) u_div_th (
      .clock(clock), .enable(adv), .num(n_th), .den(ss),
      .tag_in(1'b0), .quo(q_th), .tag_out());
   uvs_divider #(.NW(NW), .DW(9), .TW(1)) u_div_u (
      .clock(clock), .enable(adv), .num(n_u), .den(ss),
      .tag_in(1'b0), .quo(q_u), .tag_out());
   uvs_divider #(.NW(NW), .DW(9), .TW(1)) u_div_v (
      .clock(clock), .enable(adv), .num(n_v), .den(rr),
      .tag_in(1'b0), .quo(q_v), .tag_out());

   // angles into the CORDIC chains
   logic signed [35:0] cph, sph, cth, sth;
   uvs_cordic u_cor_ph (.clock(clock), .enable(adv), .angle(q_ph[31:0]),
      .cos_out(cph), .sin_out(sph));
   uvs_cordic u_cor_th (.clock(clock), .enable(adv), .angle(q_th[31:0]),
      .cos_out(cth), .sin_out(sth));

   // side data delayed alongside the CORDIC chain
   localparam int SD = uvs_pkg::CORDIC_STEPS + 1;
   uvs_pkg::side_type side_ff [SD];
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= '{err: err_d, tex_u: q_u[16:0], tex_v: q_v[16:0],
                         radius: rad_d};
         for (int k = 1; k < SD; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   // stage A: normal products
   logic signed [71:0] px_in, pz_in;
   logic signed [35:0] nx_ff, ny_ff, nz_ff, cth_ff, sth_ff;
   uvs_pkg::side_type sa_ff;
   always_comb begin
      px_in = sth * sph;
      pz_in = cth * sph;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff  <= 36'(px_in >>> 30);
         nz_ff  <= 36'(pz_in >>> 30);
         ny_ff  <= cph;
         cth_ff <= cth;
         sth_ff <= sth;
         sa_ff  <= side_ff[SD-1];
      end
   end

   function automatic logic signed [15:0] q14(input logic signed [35:0] v);
      logic signed [35:0] t;
      begin
         t = (v + 36'sd32768) >>> 16;
         if (t > 36'sd16384) t = 36'sd16384;
         if (t < -36'sd16384) t = -36'sd16384;
         return t[15:0];
      end
   endfunction

   // stage B: radius products, unit rounding and tangent selection
   logic signed [52:0] mx_ff, my_ff, mz_ff;
   logic signed [15:0] qx_ff, qy_ff, qz_ff, tx_ff, tz_ff;
   uvs_pkg::side_type sb_ff;
   logic signed [15:0] qy_in;
   always_comb qy_in = q14(ny_ff);
   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff <= nx_ff * $signed({1'b0, sa_ff.radius});
         my_ff <= ny_ff * $signed({1'b0, sa_ff.radius});
         mz_ff <= nz_ff * $signed({1'b0, sa_ff.radius});
         qx_ff <= q14(nx_ff);
         qy_ff <= qy_in;
         qz_ff <= q14(nz_ff);
         if (qy_in >= 16'sd16368 || qy_in <= -16'sd16368) begin
            tx_ff <= '0;
            tz_ff <= 16'(uvs_pkg::ONE_Q14);
         end else begin
            tx_ff <= q14(-cth_ff);
            tz_ff <= q14(sth_ff);
         end
         sb_ff <= sa_ff;
      end
   end

   function automatic logic signed [16:0] q8(input logic signed [52:0] v);
      logic signed [52:0] t;
      begin
         t = (v + 53'sd536870912) >>> 30;
         if (t > 53'sd65535) t = 53'sd65535;
         if (t < -53'sd65535) t = -53'sd65535;
         return t[16:0];
      end
   endfunction

   // output register
   logic [LAT-2:0] vld_in;
   assign vld_in = {vld_ff[LAT-3:0], req.valid};
   logic [181:0] out_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= vld_in;
         out_vld_ff <= vld_ff[LAT-2];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         if (sb_ff.err) begin
            out_ff <= {181'd0, 1'b1};
         end else begin
            out_ff <= {q8(mx_ff), q8(my_ff), q8(mz_ff), qx_ff, qy_ff, qz_ff,
                       tx_ff, 16'd0, tz_ff, sb_ff.tex_u, sb_ff.tex_v, 1'b0};
         end
      end
   end
   assign rsp.valid = out_vld_ff;
   assign rsp.data  = out_ff;
endmodule
`default_nettype wire
